// ===== hdl/srk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srk_pkg
// shared types and constants of the symmetric rank-k update block
// ----------------------------------------------------------------------------
package srk_pkg;

  localparam int unsigned DIM    = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_C = 2'd1,
    REQ_START  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_UPPER = 3'd0,
    CFG_TRANS = 3'd1,
    CFG_ORDER = 3'd2,
    CFG_INNER = 3'd3,
    CFG_ALPHA = 3'd4,
    CFG_BETA  = 3'd5
  } cfg_e;

  // back end walk states
  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_RD, ST_MAC, ST_MULA, ST_MULB, ST_LOWA, ST_LOWB,
    ST_SUM, ST_EMIT
  } state_e;

  // one queued word between front and back
  typedef struct packed {
    req_e              req;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [15:0]       a_val;
    logic [31:0]       c_val;
  } cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic        upper;
    logic        trans;
    logic [3:0]  n;
    logic [3:0]  k;
    logic [31:0] alpha;
    logic [31:0] beta;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/srk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srk_front
// accepts input words, drops unused codes, queues commands (two-entry fifo)
// ----------------------------------------------------------------------------
module srk_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [1:0]           req_type_i,
  input  wire  [2:0]           row_index_i,
  input  wire  [2:0]           col_index_i,
  input  wire  [15:0]          a_value_i,
  input  wire  [31:0]          c_value_i,
  output logic                 cmd_valid_o,
  input  wire                  cmd_ready_i,
  output srk_pkg::cmd_t        cmd_o
);
  import srk_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];
  // unused code is accepted and dropped here
  assign push = in_valid_i && in_ready_o && (req_e'(req_type_i) != REQ_NONE);
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{req: req_e'(req_type_i), row: row_index_i, col: col_index_i,
                       a_val: a_value_i, c_val: c_value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/srk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srk_back
// stores a and c, walks the triangle with an a-store read before each multiply-accumulate
// ----------------------------------------------------------------------------
module srk_back #(
  parameter int unsigned N_MAX = 8,
  parameter int unsigned K_MAX = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cmd_valid_i,
  output logic                 cmd_ready_o,
  input  srk_pkg::cmd_t        cmd_i,
  input  srk_pkg::cfg_t        cfg_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [2:0]           out_row_o,
  output logic [2:0]           out_col_o,
  output logic [31:0]          out_value_o,
  output logic                 last_o
);
  import srk_pkg::*;

  localparam logic [3:0] NLIM = 4'((N_MAX < DIM) ? N_MAX : DIM);
  localparam logic [3:0] KLIM = 4'((K_MAX < DIM) ? K_MAX : DIM);

  state_e state_q, state_d;

  logic signed [15:0] a_mem [64];
  logic signed [31:0] c_mem [64];

  logic [2:0]  row_q, row_d, col_q, col_d;
  logic [3:0]  inner_q, inner_d;
  logic [3:0]  n_q, n_d, k_q, k_d;
  logic signed [39:0] acc_q, acc_d;

  // a reads: two ports, registered
  logic [5:0] ra0, ra1;
  logic signed [15:0] av0_q, av1_q;
  logic signed [31:0] cv_q;
  logic [5:0] cidx;

  always_comb begin
    if (cfg_i.trans) begin
      ra0 = {inner_q[2:0], row_q};
      ra1 = {inner_q[2:0], col_q};
    end else begin
      ra0 = {row_q, inner_q[2:0]};
      ra1 = {col_q, inner_q[2:0]};
    end
  end
  assign cidx = {row_q, col_q};

  // product alpha*acc split: alpha x acc[19:0] and alpha x acc[39:20]
  logic signed [52:0] plo_q;   // alpha * unsigned low 20 bits
  logic signed [51:0] phi_q;   // alpha * signed high 20 bits
  logic signed [63:0] pb_q;
  logic signed [73:0] sum_q;
  logic [31:0] res_q;
  logic        emit_last_q;

  logic wr_c;
  logic [31:0] sat;

  always_comb begin
    if ($signed(sum_q[73:16]) > 58'sh7FFF_FFFF) sat = 32'h7FFF_FFFF;
    else if ($signed(sum_q[73:16]) < -58'sh8000_0000) sat = 32'h8000_0000;
    else sat = sum_q[47:16];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && cmd_i.req == REQ_LOAD_A)
      a_mem[{cmd_i.row, cmd_i.col}] <= cmd_i.a_val;
    av0_q <= a_mem[ra0];
    av1_q <= a_mem[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && cmd_i.req == REQ_LOAD_C)
      c_mem[{cmd_i.row, cmd_i.col}] <= cmd_i.c_val;
    else if (wr_c)
      c_mem[cidx] <= sat;
    cv_q <= c_mem[cidx];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_MULA: plo_q <= $signed(cfg_i.alpha) * $signed({1'b0, acc_q[19:0]});
      ST_MULB: phi_q <= $signed(cfg_i.alpha) * $signed(acc_q[39:20]);
      ST_LOWA: pb_q  <= $signed(cfg_i.beta) * cv_q;
      ST_LOWB: sum_q <= (74'(phi_q) <<< 20) + 74'(plo_q) + 74'(pb_q);
      ST_SUM: begin
        res_q <= sat;
        emit_last_q <= cfg_i.upper ? (row_q == col_q && {1'b0, col_q} == n_q - 4'd1)
                                   : ({1'b0, row_q} == n_q - 4'd1 &&
                                      {1'b0, col_q} == n_q - 4'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q <= '0; col_q <= '0; inner_q <= '0;
      n_q <= '0; k_q <= '0; acc_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d; col_q <= col_d; inner_q <= inner_d;
      n_q <= n_d; k_q <= k_d; acc_q <= acc_d;
    end
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q; inner_d = inner_q;
    n_d = n_q; k_d = k_q; acc_d = acc_q;
    cmd_ready_o = 1'b0;
    wr_c = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i && cmd_i.req == REQ_START) begin
          n_d = (cfg_i.n > NLIM) ? NLIM : cfg_i.n;
          k_d = (cfg_i.k > KLIM) ? KLIM : cfg_i.k;
          col_d = '0;
          row_d = '0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        if (n_q == 4'd0) state_d = ST_IDLE;
        else begin
          row_d = cfg_i.upper ? 3'd0 : col_q;
          inner_d = '0; acc_d = '0;
          state_d = (k_q == 4'd0) ? ST_MULA : ST_RD;
        end
      end
      ST_RD: state_d = ST_MAC;
      ST_MAC: begin
        acc_d = acc_q + 40'(av0_q * av1_q);
        inner_d = inner_q + 4'd1;
        state_d = (inner_q + 4'd1 == k_q) ? ST_MULA : ST_RD;
      end
      ST_MULA: state_d = ST_MULB;
      ST_MULB: state_d = ST_LOWA;
      ST_LOWA: state_d = ST_LOWB;
      ST_LOWB: state_d = ST_SUM;
      ST_SUM: begin
        wr_c = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (emit_last_q) state_d = ST_IDLE;
          else if ((cfg_i.upper && row_q == col_q) ||
                   (!cfg_i.upper && {1'b0, row_q} == n_q - 4'd1)) begin
            col_d = col_q + 3'd1;
            row_d = cfg_i.upper ? 3'd0 : col_q + 3'd1;
            inner_d = '0; acc_d = '0;
            state_d = (k_q == 4'd0) ? ST_MULA : ST_RD;
          end else begin
            row_d = row_q + 3'd1;
            inner_d = '0; acc_d = '0;
            state_d = (k_q == 4'd0) ? ST_MULA : ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == ST_EMIT);
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign out_value_o = res_q;
  assign last_o      = emit_last_q;

endmodule
`default_nettype wire

// ===== hdl/symmetric_rank_k_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_rank_k_update
// fixed-point syrk: c := alpha*a*a' + beta*c (alpha*a'*a when trans is set) over one triangle
// ----------------------------------------------------------------------------
// Loads of a and c stream through a two-word queue.
// A start word walks the chosen triangle column by column, rows ascending.
// Each entry runs k multiply-accumulate steps (one a-store read pair
// then one 16x16 product), then the alpha/beta products, the final sum
// and write-back, and then hands off the word.
// Loads queued behind a start wait until the walk finishes.
module symmetric_rank_k_update #(
  parameter int unsigned N_MAX = 8,
  parameter int unsigned K_MAX = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [31:0]  cfg_data_i,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [1:0]   req_type_i,
  input  wire  [2:0]   row_index_i,
  input  wire  [2:0]   col_index_i,
  input  wire  [15:0]  a_value_i,
  input  wire  [31:0]  c_value_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [2:0]   out_row_o,
  output logic [2:0]   out_col_o,
  output logic [31:0]  out_value_o,
  output logic         last_o
);
  import srk_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{upper: 1'b1, trans: 1'b0, n: 4'd8, k: 4'd8,
                 alpha: 32'h0001_0000, beta: 32'h0001_0000};
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_UPPER: cfg_q.upper <= cfg_data_i[0];
        CFG_TRANS: cfg_q.trans <= cfg_data_i[0];
        CFG_ORDER: cfg_q.n     <= cfg_data_i[3:0];
        CFG_INNER: cfg_q.k     <= cfg_data_i[3:0];
        CFG_ALPHA: cfg_q.alpha <= cfg_data_i;
        CFG_BETA:  cfg_q.beta  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accept and queue words
  srk_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .req_type_i, .row_index_i, .col_index_i, .a_value_i, .c_value_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // back: stores and triangle walk
  srk_back #(.N_MAX(N_MAX), .K_MAX(K_MAX)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd), .cfg_i(cfg_q),
    .out_valid_o, .out_ready_i, .out_row_o, .out_col_o, .out_value_o, .last_o
  );

endmodule
`default_nettype wire
